// ===== sv/dbrp_pkg.sv =====
// Shared types and constants for the double-buffered ramp player.
`default_nettype none
package dbrp_pkg;

	// Field widths of the item and result payloads.
	localparam int CMD_W       = 2;
	localparam int ACC_W       = 32;
	localparam int SAMPLE_W    = 16;
	localparam int FIRST_LEN_W = 16;
	localparam int TOTAL_LEN_W = 11;

	// Default bank depth and reset value of the sweep length register.
	localparam int HALF_DEPTH_DEF = 1024;
	localparam logic [TOTAL_LEN_W-1:0] TOTAL_LEN_RST = TOTAL_LEN_W'(200);

	// Item commands. The fourth code is unused and only reports status.
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_PREP = 2'd1,
		CMD_SWAP = 2'd2
	} cmd_t;

	// Start request from the control logic to the fill engine.
	typedef struct packed {
		logic             start;
		logic             bank;
		logic [ACC_W-1:0] level;
		logic [ACC_W-1:0] slope_a;
		logic [ACC_W-1:0] slope_b;
	} fill_req_t;

endpackage
`default_nettype wire

// ===== sv/dbrp_if.sv =====
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface dbrp_in_if;
	import dbrp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       cmd;
	logic [ACC_W-1:0]       start_level;
	logic [ACC_W-1:0]       slope_first;
	logic [ACC_W-1:0]       slope_second;
	logic [FIRST_LEN_W-1:0] first_len;

	modport source (
		output valid, cmd, start_level, slope_first, slope_second, first_len,
		input  ready
	);
	modport sink (
		input  valid, cmd, start_level, slope_first, slope_second, first_len,
		output ready
	);
endinterface

interface dbrp_out_if;
	import dbrp_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] dac_word;
	logic                word_sent;
	logic                playing;
	logic                bank_pending;

	modport source (
		output valid, dac_word, word_sent, playing, bank_pending,
		input  ready
	);
	modport sink (
		input  valid, dac_word, word_sent, playing, bank_pending,
		output ready
	);
endinterface
`default_nettype wire

// ===== sv/dbrp_store.sv =====
// Two-bank sample memory: one write port, one registered read port.
`default_nettype none
module dbrp_store #(
	parameter int HALF_DEPTH = dbrp_pkg::HALF_DEPTH_DEF,
	localparam int ADDR_W = $clog2(2 * HALF_DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [ADDR_W-1:0]             waddr,
	input  wire logic [dbrp_pkg::SAMPLE_W-1:0] wdata,
	input  wire logic                          re,
	input  wire logic [ADDR_W-1:0]             raddr,
	output logic      [dbrp_pkg::SAMPLE_W-1:0] rdata
);
	import dbrp_pkg::*;

	logic [SAMPLE_W-1:0] mem [2 * HALF_DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== sv/dbrp_fill.sv =====
// Ramp fill engine: writes one accumulator sample per cycle into the idle bank.
`default_nettype none
module dbrp_fill #(
	parameter int HALF_DEPTH = dbrp_pkg::HALF_DEPTH_DEF,
	localparam int CNT_W  = $clog2(HALF_DEPTH + 1),
	localparam int ADDR_W = $clog2(2 * HALF_DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dbrp_pkg::fill_req_t           req,
	input  wire logic [CNT_W-1:0]              first_cnt,
	input  wire logic [CNT_W-1:0]              fill_cnt,
	output logic                               busy,
	output logic                               we,
	output logic      [ADDR_W-1:0]             waddr,
	output logic      [dbrp_pkg::SAMPLE_W-1:0] wdata
);
	import dbrp_pkg::*;

	logic              busy_q;
	logic              bank_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  first_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  slope_a_q;
	logic [ACC_W-1:0]  slope_b_q;
	logic [CNT_W-1:0]  idx_nxt;
	logic [ACC_W-1:0]  step;

	assign idx_nxt = idx_q + CNT_W'(1);
	// The first slope covers entries below the clamped first length.
	assign step    = (idx_q < first_q) ? slope_a_q : slope_b_q;

	// Busy flag: set by a start, cleared after the last entry is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && idx_nxt == cnt_q) begin
			busy_q <= 1'b0;
		end
	end

	// Ramp datapath: load on start, then step the accumulator each write.
	always_ff @(posedge clk) begin
		if (req.start) begin
			bank_q    <= req.bank;
			idx_q     <= '0;
			first_q   <= first_cnt;
			cnt_q     <= fill_cnt;
			acc_q     <= req.level;
			slope_a_q <= req.slope_a;
			slope_b_q <= req.slope_b;
		end else if (busy_q) begin
			idx_q <= idx_nxt;
			acc_q <= acc_q + step;
		end
	end

	// The stored sample is the accumulator's integer half before the step.
	assign busy  = busy_q;
	assign we    = busy_q;
	assign waddr = ADDR_W'(idx_q) + (bank_q ? ADDR_W'(HALF_DEPTH) : ADDR_W'(0));
	assign wdata = acc_q[ACC_W-1 -: SAMPLE_W];
endmodule
`default_nettype wire

// ===== sv/double_buffered_ramp_player.sv =====
// Top level of the double-buffered ramp player: command control and result path.
`default_nettype none
// A tick is accepted at the input and its result follows through a read stage of
// the sample memory and an output register; ticks, swaps and unused commands
// can be accepted every cycle while the results are taken and no fill is
// running. A prepare item's result takes the same path, while the fill engine,
// starting the cycle after acceptance, writes one sample per cycle, in all
// max(min(first_len, HALF_DEPTH), min(total_len, HALF_DEPTH)) samples;
// no item is accepted until it finishes.
// The fill length is taken at acceptance. Each bank keeps a high-water mark of
// entries written since reset, and entries above it read as zero, so the store
// comes out of reset cleared with no clearing pass.
module double_buffered_ramp_player #(
	parameter int HALF_DEPTH = dbrp_pkg::HALF_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	dbrp_in_if.sink                               req,
	dbrp_out_if.source                            rsp,
	input  wire logic                             cfg_we,
	input  wire logic [dbrp_pkg::TOTAL_LEN_W-1:0] cfg_wdata
);
	import dbrp_pkg::*;

	localparam int CNT_W  = $clog2(HALF_DEPTH + 1);
	localparam int ADDR_W = $clog2(2 * HALF_DEPTH);
	localparam int CMP_W  = (CNT_W > TOTAL_LEN_W) ? CNT_W : TOTAL_LEN_W;

	// Control state.
	logic [TOTAL_LEN_W-1:0] total_len_q;
	logic                   bank_q;
	logic [CNT_W-1:0]       play_idx_q;
	logic                   pending_q;
	logic                   running_q;
	logic [CNT_W-1:0]       hw0_q;
	logic [CNT_W-1:0]       hw1_q;

	// Read stage and output register.
	logic                vld_s1;
	logic                sent_s1;
	logic                hit_s1;
	logic                run_s1;
	logic                pend_s1;
	logic                out_vld_q;
	logic [SAMPLE_W-1:0] dac_word_q;
	logic                word_sent_q;
	logic                playing_q;
	logic                pending_out_q;

	logic                accept;
	logic                adv;
	logic                fill_busy;
	cmd_t                cmd;
	logic [CMD_W-1:0]    cmd_raw;
	logic [CMP_W-1:0]    tl_ext;
	logic [CNT_W-1:0]    eff_len;
	logic [CNT_W-1:0]    first_cnt;
	logic [CNT_W-1:0]    fill_cnt;
	logic [CNT_W-1:0]    hw_play;
	logic [CNT_W-1:0]    hw_idle;
	logic                in_range;
	logic                tick_send;
	logic                tick_stop;
	logic                prep_go;
	logic                swap_go;
	logic [ADDR_W-1:0]   raddr;
	logic [SAMPLE_W-1:0] rdata;
	fill_req_t           fill_req;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [SAMPLE_W-1:0] mem_wdata;

	// Handshake: the read stage moves on when the output register is free.
	assign adv       = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !fill_busy && (!vld_s1 || adv);
	assign accept    = req.valid && req.ready;
	assign cmd_raw   = req.cmd;
	assign cmd       = cmd_t'(cmd_raw);

	// Effective sweep length and clamped first segment length.
	assign tl_ext    = CMP_W'(total_len_q);
	assign eff_len   = (tl_ext < CMP_W'(HALF_DEPTH)) ? CNT_W'(tl_ext) : CNT_W'(HALF_DEPTH);
	assign first_cnt = (req.first_len < FIRST_LEN_W'(HALF_DEPTH)) ?
	                   CNT_W'(req.first_len) : CNT_W'(HALF_DEPTH);
	assign fill_cnt  = (first_cnt > eff_len) ? first_cnt : eff_len;

	assign hw_play  = bank_q ? hw1_q : hw0_q;
	assign hw_idle  = bank_q ? hw0_q : hw1_q;
	assign in_range = play_idx_q < eff_len;

	// Command decode for the accepted item.
	always_comb begin
		tick_send = 1'b0;
		tick_stop = 1'b0;
		prep_go   = 1'b0;
		swap_go   = 1'b0;
		if (accept) begin
			unique case (cmd)
				CMD_TICK: begin
					tick_send = running_q && in_range;
					tick_stop = running_q && !in_range;
				end
				CMD_PREP: prep_go = 1'b1;
				CMD_SWAP: swap_go = 1'b1;
				default: ;
			endcase
		end
	end

	// Sweep length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_len_q <= TOTAL_LEN_RST;
		end else if (cfg_we) begin
			total_len_q <= cfg_wdata;
		end
	end

	// Play and bank state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= 1'b0;
			play_idx_q <= '0;
			pending_q  <= 1'b0;
			running_q  <= 1'b1;
		end else begin
			if (tick_send) begin
				play_idx_q <= play_idx_q + CNT_W'(1);
			end
			if (tick_stop) begin
				play_idx_q <= '0;
				running_q  <= 1'b0;
			end
			if (prep_go) begin
				pending_q <= 1'b1;
			end
			if (swap_go) begin
				running_q <= 1'b1;
				if (pending_q) begin
					bank_q     <= !bank_q;
					play_idx_q <= '0;
					pending_q  <= 1'b0;
				end
			end
		end
	end

	// High-water marks of written entries per bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw0_q <= '0;
			hw1_q <= '0;
		end else if (prep_go && fill_cnt > hw_idle) begin
			if (bank_q) begin
				hw0_q <= fill_cnt;
			end else begin
				hw1_q <= fill_cnt;
			end
		end
	end

	// Fill engine request; a prepare that writes nothing does not start it.
	always_comb begin
		fill_req.start   = prep_go && (fill_cnt != '0);
		fill_req.bank    = !bank_q;
		fill_req.level   = req.start_level;
		fill_req.slope_a = req.slope_first;
		fill_req.slope_b = req.slope_second;
	end

	dbrp_fill #(
		.HALF_DEPTH (HALF_DEPTH)
	) u_fill (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (fill_req),
		.first_cnt (first_cnt),
		.fill_cnt  (fill_cnt),
		.busy      (fill_busy),
		.we        (mem_we),
		.waddr     (mem_waddr),
		.wdata     (mem_wdata)
	);

	assign raddr = ADDR_W'(play_idx_q) + (bank_q ? ADDR_W'(HALF_DEPTH) : ADDR_W'(0));

	dbrp_store #(
		.HALF_DEPTH (HALF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (tick_send),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Read stage: status after the item, waiting for the memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sent_s1 <= tick_send;
			hit_s1  <= play_idx_q < hw_play;
			run_s1  <= (running_q && !tick_stop) || swap_go;
			pend_s1 <= (pending_q && !swap_go) || prep_go;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dac_word_q    <= (sent_s1 && hit_s1) ? rdata : '0;
			word_sent_q   <= sent_s1;
			playing_q     <= run_s1;
			pending_out_q <= pend_s1;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.dac_word     = dac_word_q;
	assign rsp.word_sent    = word_sent_q;
	assign rsp.playing      = playing_q;
	assign rsp.bank_pending = pending_out_q;
endmodule
`default_nettype wire
